[design/fdc_pkg.sv]
// Shared types and constants for the fan duty controller.
// No dependencies; every other file imports this package.
package fdc_pkg;

	localparam int TEMP_W      = 10;
	localparam int HYST_W      = 9;
	localparam int DUTY_W      = 7;
	localparam int RAW_DUTY_W  = 8;
	localparam int CMP_W       = 16;
	localparam int NOW_W       = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int PROD_W      = CMP_W + DUTY_W;
	localparam int DVSR_W      = 10;
	localparam int DIV_CNT_W   = 5;
	localparam int RECIP_W     = 24;
	localparam int RECIP_SHIFT = 30;

	localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;
	// (x * PCT_RECIP) >> RECIP_SHIFT equals x / 100 for every x below 2**PROD_W
	localparam logic [RECIP_W-1:0] PCT_RECIP = 24'd10737419;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ON_TEMP,
		REG_OFF_HYST,
		REG_FULL_TEMP,
		REG_MIN_DUTY,
		REG_FAILSAFE,
		REG_OVR_TIMEOUT,
		REG_PERIOD,
		REG_RELEASE
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_CURVE_DIV,
		ST_CMP_START,
		ST_CMP_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] dividend;
		logic [DVSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [PROD_W-1:0] quotient;
	} div_rsp_t;

endpackage

[design/fdc_in_if.sv]
// Input channel: update ticks and override commands.
// Depends on fdc_pkg for field widths.
interface fdc_in_if;
	import fdc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     func;
	logic signed [TEMP_W-1:0] temperature;
	logic                     temp_valid;
	logic [RAW_DUTY_W-1:0]    override_value;
	logic [NOW_W-1:0]         now_ms;

	modport source (output valid, func, temperature, temp_valid, override_value, now_ms,
		input ready);
	modport sink (input valid, func, temperature, temp_valid, override_value, now_ms,
		output ready);
endinterface

[design/fdc_out_if.sv]
// Output channel: applied duty, PWM compare value and status flags.
// Depends on fdc_pkg for field widths.
interface fdc_out_if;
	import fdc_pkg::*;

	logic              valid;
	logic              ready;
	logic [DUTY_W-1:0] duty;
	logic [CMP_W-1:0]  compare;
	logic              override_on;
	logic              running;

	modport source (output valid, duty, compare, override_on, running, input ready);
	modport sink (input valid, duty, compare, override_on, running, output ready);
endinterface

[design/fdc_div.sv]
// Serial restoring divider, one quotient bit per cycle, used for the
// fan curve ramp division. Depends on fdc_pkg.
module fdc_div (
	input  logic             clk,
	input  logic             arst_n,
	input  fdc_pkg::div_req_t req,
	output fdc_pkg::div_rsp_t rsp
);
	import fdc_pkg::*;

	localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(PROD_W - 1);

	logic [PROD_W-1:0]    quo_q;
	logic [DVSR_W-1:0]    rem_q;
	logic [DVSR_W-1:0]    dvsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DVSR_W:0]      trial;
	logic                 fits;
	logic [DVSR_W:0]      diff;

	assign trial = {rem_q, quo_q[PROD_W-1]};
	assign fits  = trial >= {1'b0, dvsr_q};
	assign diff  = trial - {1'b0, dvsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q  <= req.dividend;
			rem_q  <= '0;
			dvsr_q <= req.divisor;
		end else if (busy_q) begin
			// shift the next dividend bit in, subtract when the divisor fits
			quo_q <= {quo_q[PROD_W-2:0], fits};
			rem_q <= fits ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

[design/fan_duty_curve_with_override.sv]
// Fan duty controller: hysteresis fan curve, timed override, PWM compare.
// Depends on fdc_pkg, fdc_in_if, fdc_out_if and fdc_div.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+------------------------------------------
//  in_ch    | in  | valid/ready   | func, temperature, temp_valid,
//           |     |               | override_value, now_ms
//  out_ch   | out | valid/ready   | duty, compare, override_on, running
//  cfg      | in  | cfg_we        | cfg_index, cfg_wdata
//
// A request passes the evaluate, compare start, compare divide and done
// states to the output register; a fan curve ramp division adds a wait on
// the 23-step serial divider; the compare value uses a reciprocal multiply.
// One item is in work at a time; the next request is taken while a finished
// result still waits in the output register.
// Reset loads the register defaults and clears fan, override and duty state.
module fan_duty_curve_with_override (
	input  logic                             clk,
	input  logic                             arst_n,
	fdc_in_if.sink                           in_ch,
	fdc_out_if.source                        out_ch,
	input  logic                             cfg_we,
	input  logic [fdc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fdc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import fdc_pkg::*;

	// configuration registers
	logic signed [TEMP_W-1:0] on_temp_q;
	logic [HYST_W-1:0]        off_hyst_q;
	logic signed [TEMP_W-1:0] full_temp_q;
	logic [DUTY_W-1:0]        min_duty_q;
	logic [RAW_DUTY_W-1:0]    failsafe_q;
	logic [NOW_W-1:0]         timeout_q;
	logic [CMP_W-1:0]         period_q;
	logic [RAW_DUTY_W-1:0]    release_q;

	// controller state
	state_t            state_q, state_d;
	logic              fan_q;
	logic              ovr_q;
	logic [DUTY_W-1:0] ovr_level_q;
	logic [NOW_W-1:0]  ovr_time_q;
	logic [DUTY_W-1:0] duty_q;
	logic [CMP_W-1:0]  cmp_q;
	logic [PROD_W-1:0] prod_q;

	// latched request
	logic                     in_func_q;
	logic signed [TEMP_W-1:0] in_temp_q;
	logic                     in_tvalid_q;
	logic [RAW_DUTY_W-1:0]    in_ov_q;
	logic [NOW_W-1:0]         in_now_q;

	// output register
	logic              out_valid_q;
	logic [DUTY_W-1:0] out_duty_q;
	logic [CMP_W-1:0]  out_cmp_q;
	logic              out_ovr_q;
	logic              out_run_q;

	logic in_acc;
	logic out_free;
	logic out_load;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// evaluation terms
	logic [NOW_W-1:0]           elapsed;
	logic                       ovr_live;
	logic signed [TEMP_W:0]     t_ext;
	logic signed [TEMP_W:0]     on_ext;
	logic signed [TEMP_W:0]     off_thr;
	logic signed [TEMP_W:0]     span;
	logic signed [TEMP_W:0]     t_above;
	logic                       below_off;
	logic                       below_on;
	logic                       at_full;
	logic                       span_pos;
	logic [DVSR_W-1:0]          above;
	logic [DUTY_W-1:0]          fs_duty;
	logic [DUTY_W-1:0]          cmd_level;
	logic [CMP_W-1:0]           mul_a;
	logic [DUTY_W-1:0]          mul_b;
	logic [PROD_W-1:0]          product;
	logic [PROD_W+RECIP_W-1:0]  recip_prod;

	logic              eval_div;
	logic [DUTY_W-1:0] eval_duty;
	logic              fan_d;
	logic              ovr_d;
	logic              ovr_set;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;
	assign out_load    = (state_q == ST_DONE) && out_free;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_temp_q   <= 10'sd40;
			off_hyst_q  <= 9'd5;
			full_temp_q <= 10'sd60;
			min_duty_q  <= 7'd30;
			failsafe_q  <= 8'd100;
			timeout_q   <= 32'd1000;
			period_q    <= 16'd40;
			release_q   <= 8'd255;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ON_TEMP:     on_temp_q   <= $signed(cfg_wdata[TEMP_W-1:0]);
				REG_OFF_HYST:    off_hyst_q  <= cfg_wdata[HYST_W-1:0];
				REG_FULL_TEMP:   full_temp_q <= $signed(cfg_wdata[TEMP_W-1:0]);
				REG_MIN_DUTY:    min_duty_q  <= cfg_wdata[DUTY_W-1:0];
				REG_FAILSAFE:    failsafe_q  <= cfg_wdata[RAW_DUTY_W-1:0];
				REG_OVR_TIMEOUT: timeout_q   <= cfg_wdata[NOW_W-1:0];
				REG_PERIOD:      period_q    <= cfg_wdata[CMP_W-1:0];
				REG_RELEASE:     release_q   <= cfg_wdata[RAW_DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_func_q   <= in_ch.func;
			in_temp_q   <= in_ch.temperature;
			in_tvalid_q <= in_ch.temp_valid;
			in_ov_q     <= in_ch.override_value;
			in_now_q    <= in_ch.now_ms;
		end
	end

	// curve and override terms
	assign elapsed   = in_now_q - ovr_time_q;
	assign ovr_live  = ovr_q && (elapsed < timeout_q);
	assign t_ext     = {in_temp_q[TEMP_W-1], in_temp_q};
	assign on_ext    = {on_temp_q[TEMP_W-1], on_temp_q};
	assign off_thr   = on_ext - $signed({2'b00, off_hyst_q});
	assign span      = {full_temp_q[TEMP_W-1], full_temp_q} - on_ext;
	assign t_above   = t_ext - on_ext;
	assign below_off = t_ext <= off_thr;
	assign below_on  = in_temp_q < on_temp_q;
	assign at_full   = in_temp_q >= full_temp_q;
	assign span_pos  = !span[TEMP_W] && (span != '0);
	assign above     = t_above[TEMP_W] ? '0 : t_above[DVSR_W-1:0];
	assign fs_duty   = (failsafe_q > {1'b0, DUTY_FULL}) ? DUTY_FULL : failsafe_q[DUTY_W-1:0];
	assign cmd_level = (in_ov_q > {1'b0, DUTY_FULL}) ? DUTY_FULL : in_ov_q[DUTY_W-1:0];

	// shared multiplier feeds the divider and the compare product register
	always_comb begin
		if (state_q == ST_EVAL) begin
			mul_a = {{(CMP_W-DVSR_W){1'b0}}, above};
			mul_b = DUTY_FULL - min_duty_q;
		end else begin
			mul_a = period_q;
			mul_b = duty_q;
		end
	end
	assign product = {{DUTY_W{1'b0}}, mul_a} * {{CMP_W{1'b0}}, mul_b};

	// divide the registered compare product by 100
	assign recip_prod = {{RECIP_W{1'b0}}, prod_q} * {{PROD_W{1'b0}}, PCT_RECIP};

	always_comb begin
		eval_div  = 1'b0;
		eval_duty = duty_q;
		fan_d     = fan_q;
		ovr_d     = ovr_q;
		ovr_set   = 1'b0;
		if (!in_func_q) begin
			ovr_d = ovr_live;
			if (ovr_live) begin
				eval_duty = ovr_level_q;
			end else if (!in_tvalid_q) begin
				eval_duty = fs_duty;
			end else if (fan_q && below_off) begin
				fan_d     = 1'b0;
				eval_duty = '0;
			end else if (!fan_q && below_on) begin
				eval_duty = '0;
			end else begin
				fan_d = 1'b1;
				// a min duty above full scale always ends at full scale
				if (at_full || !span_pos || (min_duty_q > DUTY_FULL)) begin
					eval_duty = DUTY_FULL;
				end else begin
					eval_div = 1'b1;
				end
			end
		end else if (in_ov_q == release_q) begin
			ovr_d = 1'b0;
		end else begin
			ovr_d     = 1'b1;
			ovr_set   = 1'b1;
			eval_duty = cmd_level;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		div_req.start    = 1'b0;
		div_req.dividend = product;
		div_req.divisor  = span[DVSR_W-1:0];
		case (state_q)
			ST_IDLE: begin
				if (in_acc) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				div_req.start = eval_div;
				state_d       = eval_div ? ST_CURVE_DIV : ST_CMP_START;
			end
			ST_CURVE_DIV: begin
				if (div_rsp.done) state_d = ST_CMP_START;
			end
			ST_CMP_START: begin
				state_d = ST_CMP_DIV;
			end
			ST_CMP_DIV: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fan_q       <= 1'b0;
			ovr_q       <= 1'b0;
			ovr_level_q <= '0;
			ovr_time_q  <= '0;
			duty_q      <= '0;
		end else begin
			if (state_q == ST_EVAL) begin
				fan_q  <= fan_d;
				ovr_q  <= ovr_d;
				duty_q <= eval_duty;
				if (ovr_set) begin
					ovr_level_q <= cmd_level;
					ovr_time_q  <= in_now_q;
				end
			end
			if ((state_q == ST_CURVE_DIV) && div_rsp.done) begin
				duty_q <= min_duty_q + div_rsp.quotient[DUTY_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CMP_START) begin
			prod_q <= product;
		end
		if (state_q == ST_CMP_DIV) begin
			cmp_q <= recip_prod[RECIP_SHIFT +: CMP_W];
		end
	end

	fdc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// output register: hold until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_duty_q <= duty_q;
			out_cmp_q  <= cmp_q;
			out_ovr_q  <= ovr_q;
			out_run_q  <= fan_q;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.duty        = out_duty_q;
	assign out_ch.compare     = out_cmp_q;
	assign out_ch.override_on = out_ovr_q;
	assign out_ch.running     = out_run_q;

	a_duty_max: assert property (@(posedge clk) disable iff (!arst_n)
		duty_q <= DUTY_FULL)
		else $error("applied duty above full scale");

	a_level_max: assert property (@(posedge clk) disable iff (!arst_n)
		ovr_level_q <= DUTY_FULL)
		else $error("override level above full scale");

	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_EVAL))
		else $error("accepted request not evaluated");

	a_cmp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (cmp_q <= period_q))
		else $error("compare value exceeds period");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_DONE) |-> !div_rsp.busy)
		else $error("divider busy outside a computation");

endmodule
